// ----- rtl/core/npc_pkg.sv -----
// package: types, palette and helpers for the nearest palette color block
package npc_pkg;

	localparam int unsigned PAL_ENTRIES = 12;
	localparam int unsigned IDX_W       = 4;
	localparam int unsigned SQ_W        = 18;
	localparam int unsigned DIST_W      = 9;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic [IDX_W-1:0]  color_index;
		logic [7:0]        out_red;
		logic [7:0]        out_green;
		logic [7:0]        out_blue;
		logic [DIST_W-1:0] distance;
	} res_t;

	// best match carried along the chain
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] root;
	} best_t;

	function automatic logic [23:0] pal_rgb(input logic [IDX_W-1:0] i);
		logic [23:0] c;
		case (i)
			4'd0:    c = 24'h21252b;
			4'd1:    c = 24'hd6d9df;
			4'd2:    c = 24'hd55a4d;
			4'd3:    c = 24'h8e5236;
			4'd4:    c = 24'hc7804f;
			4'd5:    c = 24'hdfbe6c;
			4'd6:    c = 24'h8ec379;
			4'd7:    c = 24'h26a69a;
			4'd8:    c = 24'h61adcb;
			4'd9:    c = 24'h2a5cb9;
			4'd10:   c = 24'h9373dd;
			4'd11:   c = 24'hc678dd;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

	function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return d * d;
	endfunction

endpackage

// ----- rtl/core/nearest_palette_color_top.sv -----
// top level: chain of palette cells with valid pipeline and output register
// Maps each RGB pixel to the nearest palette entry (floor of Euclidean distance,
// ties to the lowest index). One beat is accepted per cycle while the output is not
// stalled. Each beat passes the chain of cells, each cell taking three stages
// (squared distance, two halves of the floor square root), then the output
// register. The whole pipe advances when the output register is empty or being
// taken, so stall on the input equals stall held back from the output.
// PALETTE_SIZE is clamped to 1..12.
module nearest_palette_color_top #(
	parameter int unsigned PALETTE_SIZE = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  npc_pkg::pix_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output npc_pkg::res_t  out_data
);
	localparam int unsigned N     = (PALETTE_SIZE < 1) ? 1 :
		(PALETTE_SIZE > npc_pkg::PAL_ENTRIES) ? npc_pkg::PAL_ENTRIES : PALETTE_SIZE;
	localparam int unsigned DEPTH = 3 * N;

	// advance enable for the whole chain
	logic en;
	logic [DEPTH-1:0] vld_q;
	npc_pkg::pix_t    pix_c [N+1];
	npc_pkg::best_t   best_c [N+1];
	logic [23:0]      col;

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;
	assign pix_c[0]  = in_data;
	assign best_c[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		npc_cell #(.ENTRY(4'(i))) u_cell (
			.clk(clk), .en(en),
			.pix_in(pix_c[i]), .first_in(i == 0),
			.best_in(best_c[i]),
			.pix_out(pix_c[i+1]), .best_out(best_c[i+1])
		);
	end

	// valid shift line tracks beats through the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[DEPTH-2:0], in_valid};
			out_valid <= vld_q[DEPTH-1];
		end
	end

	assign col = npc_pkg::pal_rgb(best_c[N].idx);

	// output register (payload, no reset)
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.color_index <= best_c[N].idx;
			out_data.out_red     <= col[23:16];
			out_data.out_green   <= col[15:8];
			out_data.out_blue    <= col[7:0];
			out_data.distance    <= best_c[N].root;
		end
	end

`ifndef SYNTHESIS
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("held result changed");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.color_index < 4'(N))
		else $error("index out of range");
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.distance <= 9'd441)
		else $error("distance out of range");
`endif
endmodule

// ----- rtl/core/npc_cell.sv -----
// one palette cell: squared distance, then a pipelined floor square root
module npc_cell #(
	parameter logic [3:0] ENTRY = 4'd0
) (
	input  logic                    clk,
	input  logic                    en,
	input  npc_pkg::pix_t           pix_in,
	input  logic                    first_in,
	input  npc_pkg::best_t          best_in,
	output npc_pkg::pix_t           pix_out,
	output npc_pkg::best_t          best_out
);
	localparam logic [23:0] COL = npc_pkg::pal_rgb(ENTRY);

	// stage 1: sum of squares
	logic [npc_pkg::SQ_W-1:0] sum_s1;
	npc_pkg::pix_t            pix_s1;
	npc_pkg::best_t           best_s1;
	logic                     first_s1;
	// stage 2/3: square root, 5 then 4 steps (bits 8..4 then 3..0)
	logic [npc_pkg::SQ_W-1:0] rem_s2;
	logic [npc_pkg::DIST_W-1:0] root_s2;
	npc_pkg::pix_t            pix_s2;
	npc_pkg::best_t           best_s2;
	logic                     first_s2;

	logic [npc_pkg::SQ_W-1:0]   rem_a, rem_b;
	logic [npc_pkg::DIST_W-1:0] root_a, root_b;
	logic [npc_pkg::SQ_W+1:0]   trial;

	// restoring sqrt, one result bit per step
	always_comb begin
		rem_a  = sum_s1;
		root_a = '0;
		for (int k = 8; k >= 4; k--) begin
			trial = {2'b0, 18'(root_a) << (k + 1)} + (20'd1 << (2 * k));
			if (trial <= {2'b0, rem_a}) begin
				rem_a  = rem_a - trial[npc_pkg::SQ_W-1:0];
				root_a = root_a | (9'd1 << k);
			end
		end
		rem_b  = rem_s2;
		root_b = root_s2;
		for (int k = 3; k >= 0; k--) begin
			trial = {2'b0, 18'(root_b) << (k + 1)} + (20'd1 << (2 * k));
			if (trial <= {2'b0, rem_b}) begin
				rem_b  = rem_b - trial[npc_pkg::SQ_W-1:0];
				root_b = root_b | (9'd1 << k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= 18'(npc_pkg::chan_sq(pix_in.red, COL[23:16]))
				+ 18'(npc_pkg::chan_sq(pix_in.green, COL[15:8]))
				+ 18'(npc_pkg::chan_sq(pix_in.blue, COL[7:0]));
			pix_s1  <= pix_in;
			best_s1 <= best_in;
			first_s1 <= first_in;
			rem_s2  <= rem_a;
			root_s2 <= root_a;
			pix_s2  <= pix_s1;
			best_s2 <= best_s1;
			first_s2 <= first_s1;
			pix_out <= pix_s2;
			if (first_s2 || root_b < best_s2.root) begin
				best_out.idx  <= ENTRY;
				best_out.root <= root_b;
			end else begin
				best_out <= best_s2;
			end
		end
	end
endmodule
